// File: sv/npst_pkg.sv
package npst_pkg;

    localparam int SWEEP_W = 11;

    localparam logic [2:0] OP_ALLOC      = 3'd0;
    localparam logic [2:0] OP_PROGRAM    = 3'd1;
    localparam logic [2:0] OP_INVALIDATE = 3'd2;
    localparam logic [2:0] OP_ERASE      = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;
    localparam logic [2:0] OP_COUNT      = 3'd5;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] CFG_BLOCKS_IN_USE     = 2'd0;
    localparam logic [1:0] CFG_PAGES_IN_USE      = 2'd1;
    localparam logic [1:0] CFG_START_WRITE_BLOCK = 2'd2;

    localparam logic [6:0] REG_RESET_IN_USE = 7'd64;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  block_idx;
        logic [5:0]  page_idx;
        logic [31:0] lpn;
        logic [5:0]  pool_block;
        logic        pool_valid;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [5:0]  alloc_block;
        logic [5:0]  alloc_page;
        logic        pool_taken;
        logic        block_is_free;
        logic [6:0]  valid_pages;
        logic [6:0]  invalid_pages;
        logic [31:0] wear_count;
        logic [6:0]  free_blocks;
    } t_res;

    typedef struct packed {
        logic               accept;
        logic               eval;
        logic               cnt_rd;
        logic               cnt_acc;
        logic               cnt_last;
        logic               clr;
        logic [SWEEP_W-1:0] sweep;
    } t_cmd;

    typedef struct packed {
        logic       reread;
        logic [6:0] blocks_in_use;
    } t_sts;

endpackage

// File: sv/nand_page_state_tracker_core.sv
// Flow: a request is accepted in idle, then its block record is read, evaluated
// and written back; allocate rereads the pool block when it switches, and count
// sweeps the records of the blocks in use. busy is high until the request is done,
// so requests go one at a time, set by the per-block record RAM read-modify-write.
// Reset: synchronous active low, then a clear of all NUM_BLOCKS records (busy high).
// Results are held for one cycle by o_done; the receiver cannot stall.
module nand_page_state_tracker_core #(
    parameter int NUM_BLOCKS  = 64,
    parameter int BLOCK_PAGES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  npst_pkg::t_req  i_req,
    output logic            o_done,
    output npst_pkg::t_res  o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [6:0]      i_cfg_wdata
);
    import npst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    npst_ctrl #(.NUM_BLOCKS(NUM_BLOCKS)) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_op   (i_req.op),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    npst_dp #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_PAGES(BLOCK_PAGES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_res      (o_res)
    );
endmodule

// File: sv/npst_ram.sv
module npst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/npst_ctrl.sv
module npst_ctrl #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_op,
    input  npst_pkg::t_sts    i_sts,
    output npst_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import npst_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_COUNT = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [SWEEP_W-1:0] r_sweep, n_sweep;

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        o_cmd = '0;
        o_cmd.sweep = r_sweep;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_sweep == SWEEP_W'(NUM_BLOCKS - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_COUNT) begin
                        o_cmd.cnt_rd = 1'b1;
                        n_sweep = r_sweep + 1'b1;
                        n_state = S_COUNT;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.reread) begin
                    n_state = S_IDLE;
                end
            end
            S_COUNT: begin
                o_cmd.cnt_rd = 1'b1;
                o_cmd.cnt_acc = 1'b1;
                if (r_sweep == SWEEP_W'(i_sts.blocks_in_use)) begin
                    o_cmd.cnt_last = 1'b1;
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: sv/npst_dp.sv
module npst_dp #(
    parameter int NUM_BLOCKS  = 64,
    parameter int BLOCK_PAGES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npst_pkg::t_req    i_req,
    input  npst_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_wdata,
    output npst_pkg::t_sts    o_sts,
    output logic              o_done,
    output npst_pkg::t_res    o_res
);
    import npst_pkg::*;

    localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PW  = (BLOCK_PAGES > 1) ? $clog2(BLOCK_PAGES) : 1;
    localparam int CL  = $clog2(BLOCK_PAGES + 1);
    localparam int CW  = (CL > 7) ? CL : 7;
    localparam int RWD = 2 * BLOCK_PAGES;

    typedef struct packed {
        logic [CW-1:0] valid;
        logic [CW-1:0] invalid;
        logic [CW-1:0] free;
        logic [CW-1:0] wptr;
        logic [31:0]   wear;
    } t_rec;

    function automatic logic [6:0] sat_cfg(input logic [6:0] v, input int hi);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (32'(v) > hi) begin
            r = 7'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [6:0]  r_biu, r_piu;
    logic [5:0]  r_cur;
    t_req        r_req;
    logic        r_switched;
    logic [AW-1:0] r_addr;
    logic [6:0]  r_cnt;
    logic        r_done;
    t_res        r_res;

    t_rec        rec_q, rec_w;
    logic [RWD-1:0] row_q, row_w;
    logic [AW-1:0]  raddr, waddr;
    logic        we;
    logic        reread, do_switch, done;
    t_res        res;
    logic [CW-1:0] piu_c;
    logic        bad_cur, blk_ok, pg_ok;
    logic [PW:0] bit_i;
    logic [1:0]  pstate;
    logic        hit;

    npst_ram #(.WIDTH($bits(t_rec)), .DEPTH(NUM_BLOCKS)) u_rec (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(rec_w),
        .i_raddr(raddr),
        .o_rdata(rec_q)
    );

    npst_ram #(.WIDTH(RWD), .DEPTH(NUM_BLOCKS)) u_row (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(row_w),
        .i_raddr(raddr),
        .o_rdata(row_q)
    );

    always_comb begin
        if (i_cmd.cnt_rd) begin
            raddr = AW'(i_cmd.sweep);
        end else if (i_cmd.accept) begin
            raddr = (i_req.op == OP_ALLOC) ? AW'(r_cur) : AW'(i_req.block_idx);
        end else begin
            raddr = AW'(r_req.pool_block);
        end
    end

    assign piu_c  = CW'(r_piu);
    assign blk_ok = (7'(r_req.block_idx) < r_biu);
    assign pg_ok  = (7'(r_req.page_idx) < r_piu);
    assign bit_i  = {PW'(r_req.page_idx), 1'b0};
    assign pstate = row_q[bit_i +: 2];
    assign bad_cur = (7'(r_cur) >= r_biu) || (rec_q.wptr >= piu_c);
    assign hit    = (rec_q.free == piu_c);

    always_comb begin
        we = 1'b0;
        waddr = r_addr;
        rec_w = rec_q;
        row_w = row_q;
        res = '0;
        reread = 1'b0;
        do_switch = 1'b0;
        done = 1'b0;
        if (i_cmd.clr) begin
            we = 1'b1;
            waddr = AW'(i_cmd.sweep);
            rec_w = '0;
            rec_w.free = CW'(sat_cfg(REG_RESET_IN_USE, BLOCK_PAGES));
            row_w = '0;
        end else if (i_cmd.eval) begin
            done = 1'b1;
            unique case (r_req.op)
                OP_ALLOC: begin
                    res.pool_taken = r_switched;
                    if (!r_switched && bad_cur) begin
                        if (r_req.pool_valid && (7'(r_req.pool_block) < r_biu)) begin
                            do_switch = 1'b1;
                            reread = 1'b1;
                            done = 1'b0;
                        end
                    end else if (rec_q.free != '0 && rec_q.wptr < piu_c) begin
                        res.ok = 1'b1;
                        res.alloc_block = r_switched ? r_req.pool_block : r_cur;
                        res.alloc_page = 6'(rec_q.wptr);
                        rec_w.wptr = rec_q.wptr + 1'b1;
                        we = 1'b1;
                    end
                end
                OP_PROGRAM: begin
                    if (blk_ok && pg_ok && rec_q.free != '0) begin
                        res.ok = 1'b1;
                        row_w[bit_i +: 2] = ST_VALID;
                        if (rec_q.valid < CW'(127)) begin
                            rec_w.valid = rec_q.valid + 1'b1;
                        end
                        rec_w.free = rec_q.free - 1'b1;
                        we = 1'b1;
                    end
                end
                OP_INVALIDATE: begin
                    if (blk_ok && pg_ok && pstate == ST_VALID && rec_q.valid != '0) begin
                        res.ok = 1'b1;
                        row_w[bit_i +: 2] = ST_INVALID;
                        rec_w.valid = rec_q.valid - 1'b1;
                        if (rec_q.invalid < CW'(127)) begin
                            rec_w.invalid = rec_q.invalid + 1'b1;
                        end
                        we = 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (blk_ok) begin
                        res.ok = 1'b1;
                        row_w = '0;
                        rec_w.valid = '0;
                        rec_w.invalid = '0;
                        rec_w.free = piu_c;
                        rec_w.wptr = '0;
                        if (rec_q.wear != 32'hFFFF_FFFF) begin
                            rec_w.wear = rec_q.wear + 1'b1;
                        end
                        we = 1'b1;
                    end
                end
                OP_QUERY: begin
                    if (blk_ok) begin
                        res.ok = 1'b1;
                        res.block_is_free = hit;
                        res.valid_pages = 7'(rec_q.valid);
                        res.invalid_pages = 7'(rec_q.invalid);
                        res.wear_count = rec_q.wear;
                    end
                end
                default: res = '0;
            endcase
        end else if (i_cmd.cnt_last) begin
            done = 1'b1;
            res.ok = 1'b1;
            res.free_blocks = r_cnt + 7'(hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
            r_addr <= raddr;
        end else if (do_switch) begin
            r_addr <= raddr;
        end
        if (i_cmd.accept) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_acc) begin
            r_cnt <= r_cnt + 7'(hit);
        end
        r_res <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= sat_cfg(REG_RESET_IN_USE, NUM_BLOCKS);
            r_piu <= sat_cfg(REG_RESET_IN_USE, BLOCK_PAGES);
            r_cur <= '0;
            r_switched <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= done;
            if (i_cmd.accept) begin
                r_switched <= 1'b0;
            end else if (do_switch) begin
                r_switched <= 1'b1;
            end
            if (do_switch) begin
                r_cur <= r_req.pool_block;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BLOCKS_IN_USE: r_biu <= sat_cfg(i_cfg_wdata, NUM_BLOCKS);
                    CFG_PAGES_IN_USE:  r_piu <= sat_cfg(i_cfg_wdata, BLOCK_PAGES);
                    CFG_START_WRITE_BLOCK: begin
                        r_cur <= i_cfg_wdata[5:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.reread = reread;
    assign o_sts.blocks_in_use = r_biu;
    assign o_done = r_done;
    assign o_res = r_res;
endmodule

// File: sim/tb_nand_page_state_tracker_core.sv
`timescale 1ns / 100ps

module tb_nand_page_state_tracker_core;
    import npst_pkg::*;

    localparam int NBLK = 64;
    localparam int NPG = 64;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_done;
    t_res       o_res;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [6:0] i_cfg_wdata = '0;

    nand_page_state_tracker_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // tracker copy of every block's state
    logic [1:0]  page_st [NBLK*NPG];
    int          valid_cnt [NBLK];
    int          invalid_cnt [NBLK];
    int          free_cnt [NBLK];
    int          wr_ptr [NBLK];
    logic [31:0] wear [NBLK];
    int          cur_blk;
    int          nblk_use;
    int          npg_use;

    t_res pending_results[$];
    bit   failed = 1'b0;
    bit   quiet = 1'b0;
    int   cycles = 0;
    t_row dir_rows[$];

    function automatic int clamp_cfg(logic [6:0] v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic void clear_blk(int b);
        for (int p = 0; p < NPG; p++) page_st[b*NPG+p] = ST_FREE;
        valid_cnt[b] = 0;
        invalid_cnt[b] = 0;
        free_cnt[b] = npg_use;
        wr_ptr[b] = 0;
    endfunction

    function automatic void tracker_reset();
        nblk_use = 64;
        npg_use = 64;
        cur_blk = 0;
        for (int b = 0; b < NBLK; b++) begin
            clear_blk(b);
            wear[b] = '0;
        end
    endfunction

    function automatic t_res track_command(t_req r);
        t_res res;
        int   b;
        int   idx;
        int   cnt;
        res = '0;
        case (r.op)
            OP_ALLOC: begin
                b = cur_blk;
                if (b >= nblk_use || wr_ptr[b] >= npg_use) begin
                    if (!r.pool_valid || r.pool_block >= nblk_use) return res;
                    cur_blk = int'(r.pool_block);
                    b = cur_blk;
                    res.pool_taken = 1'b1;
                end
                if (free_cnt[b] == 0 || wr_ptr[b] >= npg_use) return res;
                res.ok = 1'b1;
                res.alloc_block = b[5:0];
                res.alloc_page = wr_ptr[b][5:0];
                wr_ptr[b]++;
            end
            OP_PROGRAM: begin
                b = int'(r.block_idx);
                if (b >= nblk_use || r.page_idx >= npg_use || free_cnt[b] == 0) return res;
                page_st[b*NPG+int'(r.page_idx)] = ST_VALID;
                if (valid_cnt[b] < 127) valid_cnt[b]++;
                free_cnt[b]--;
                res.ok = 1'b1;
            end
            OP_INVALIDATE: begin
                b = int'(r.block_idx);
                if (b >= nblk_use || r.page_idx >= npg_use) return res;
                idx = b*NPG + int'(r.page_idx);
                if (page_st[idx] != ST_VALID || valid_cnt[b] == 0) return res;
                page_st[idx] = ST_INVALID;
                valid_cnt[b]--;
                if (invalid_cnt[b] < 127) invalid_cnt[b]++;
                res.ok = 1'b1;
            end
            OP_ERASE: begin
                b = int'(r.block_idx);
                if (b >= nblk_use) return res;
                clear_blk(b);
                if (wear[b] != 32'hFFFF_FFFF) wear[b]++;
                res.ok = 1'b1;
            end
            OP_QUERY: begin
                b = int'(r.block_idx);
                if (b >= nblk_use) return res;
                res.ok = 1'b1;
                res.block_is_free = (free_cnt[b] == npg_use);
                res.valid_pages = valid_cnt[b][6:0];
                res.invalid_pages = invalid_cnt[b][6:0];
                res.wear_count = wear[b];
            end
            OP_COUNT: begin
                cnt = 0;
                for (int k = 0; k < nblk_use; k++)
                    if (free_cnt[k] == npg_use) cnt++;
                res.ok = 1'b1;
                res.free_blocks = cnt[6:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_res exp_r;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_nand_page_state_tracker_core: FAIL");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_res);
                failed = 1'b1;
            end else begin
                exp_r = pending_results.pop_front();
                cmp_field("ok", 32'(exp_r.ok), 32'(o_res.ok));
                cmp_field("alloc_block", 32'(exp_r.alloc_block), 32'(o_res.alloc_block));
                cmp_field("alloc_page", 32'(exp_r.alloc_page), 32'(o_res.alloc_page));
                cmp_field("pool_taken", 32'(exp_r.pool_taken), 32'(o_res.pool_taken));
                cmp_field("block_is_free", 32'(exp_r.block_is_free),
                          32'(o_res.block_is_free));
                cmp_field("valid_pages", 32'(exp_r.valid_pages), 32'(o_res.valid_pages));
                cmp_field("invalid_pages", 32'(exp_r.invalid_pages),
                          32'(o_res.invalid_pages));
                cmp_field("wear_count", exp_r.wear_count, o_res.wear_count);
                cmp_field("free_blocks", 32'(exp_r.free_blocks), 32'(o_res.free_blocks));
            end
        end
    end

    task automatic send_request(t_req r, bit typed, t_res typed_res);
        t_res pred;
        if (!quiet && $urandom_range(99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = track_command(r);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLOCKS_IN_USE:     nblk_use = clamp_cfg(val, NBLK);
            CFG_PAGES_IN_USE:      npg_use = clamp_cfg(val, NPG);
            CFG_START_WRITE_BLOCK: cur_blk = int'(val[5:0]);
            default: ;
        endcase
    endtask

    function automatic t_req mk(logic [2:0] op, logic [5:0] blk, logic [5:0] pg,
                                logic [31:0] lpn, logic [5:0] pool, logic pv);
        t_req r;
        r.op = op;
        r.block_idx = blk;
        r.page_idx = pg;
        r.lpn = lpn;
        r.pool_block = pool;
        r.pool_valid = pv;
        return r;
    endfunction

    function automatic void add_row(t_req r, bit typed, t_res res);
        t_row row;
        row.req = r;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    function automatic t_req rand_cmd();
        t_req r;
        int   sel;
        int   near;
        r = '0;
        r.lpn = $urandom;
        r.pool_valid = ($urandom_range(99) < 60);
        r.pool_block = 6'(($urandom_range(9) < 8) ? $urandom_range(nblk_use - 1) : $urandom);
        near = (nblk_use < 4) ? nblk_use : 4;
        sel = $urandom_range(99);
        if (sel < 8) r.block_idx = 6'($urandom);
        else if (sel < 60) r.block_idx = 6'($urandom_range(near - 1));
        else r.block_idx = 6'($urandom_range(nblk_use - 1));
        r.page_idx = 6'(($urandom_range(9) == 0) ? $urandom : $urandom_range(npg_use - 1));
        sel = $urandom_range(99);
        if (sel < 25) r.op = OP_ALLOC;
        else if (sel < 45) r.op = OP_PROGRAM;
        else if (sel < 65) r.op = OP_INVALIDATE;
        else if (sel < 73) r.op = OP_ERASE;
        else if (sel < 87) r.op = OP_QUERY;
        else if (sel < 96) r.op = OP_COUNT;
        else r.op = 3'($urandom_range(7, 6));
        return r;
    endfunction

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) begin
            quiet = (k >= n/3 && k < n/3 + 40);
            send_request(rand_cmd(), 1'b0, '0);
        end
        quiet = 1'b0;
    endtask

    initial begin
        t_res e;
        tracker_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        e = '0; e.ok = 1'b1; e.block_is_free = 1'b1;
        add_row(mk(OP_QUERY, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b1, e);
        e = '0; e.ok = 1'b1; e.free_blocks = 7'd64;
        add_row(mk(OP_COUNT, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b1, e);
        e = '0; e.ok = 1'b1;
        add_row(mk(OP_ALLOC, 6'd0, 6'd0, 32'd0, 6'd63, 1'b1), 1'b1, e);
        add_row(mk(OP_PROGRAM, 6'd0, 6'd0, 32'hFFFF_FFFF, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_PROGRAM, 6'd63, 6'd63, 32'h0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_PROGRAM, 6'd0, 6'd0, 32'h1234_5678, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_INVALIDATE, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        e = '0;
        add_row(mk(OP_INVALIDATE, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b1, e);
        add_row(mk(OP_INVALIDATE, 6'd5, 6'd9, 32'd0, 6'd0, 1'b0), 1'b1, e);
        add_row(mk(OP_QUERY, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_QUERY, 6'd63, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_COUNT, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_ERASE, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_ERASE, 6'd63, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(OP_QUERY, 6'd63, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        add_row(mk(3'd6, 6'd1, 6'd1, 32'hFFFF_FFFF, 6'd1, 1'b1), 1'b1, e);
        add_row(mk(3'd7, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b1, e);
        add_row(mk(OP_ALLOC, 6'd0, 6'd0, 32'd0, 6'd0, 1'b0), 1'b0, '0);
        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        run_random(100);
        drain();

        // small geometry: bad indices, full write block, pool switches
        write_reg(CFG_BLOCKS_IN_USE, 7'd4);
        write_reg(CFG_PAGES_IN_USE, 7'd4);
        write_reg(CFG_START_WRITE_BLOCK, 7'd3);
        for (int b = 0; b < 4; b++) send_request(mk(OP_ERASE, b[5:0], 6'd0, 32'd0, 6'd0, 1'b0),
                                                 1'b0, '0);
        send_request(mk(OP_PROGRAM, 6'd4, 6'd0, 32'd0, 6'd0, 1'b0), 1'b1, '0);
        send_request(mk(OP_PROGRAM, 6'd0, 6'd4, 32'd0, 6'd0, 1'b0), 1'b1, '0);
        send_request(mk(OP_QUERY, 6'd63, 6'd0, 32'd0, 6'd0, 1'b0), 1'b1, '0);
        run_random(140);
        drain();

        // extremes: write clamped low and high, start block out of range
        write_reg(CFG_BLOCKS_IN_USE, 7'd0);
        write_reg(CFG_PAGES_IN_USE, 7'd127);
        write_reg(CFG_START_WRITE_BLOCK, 7'd127);
        run_random(60);
        drain();

        write_reg(CFG_BLOCKS_IN_USE, 7'd127);
        write_reg(CFG_PAGES_IN_USE, 7'd1);
        write_reg(CFG_START_WRITE_BLOCK, 7'd2);
        run_random(100);
        drain();

        write_reg(CFG_BLOCKS_IN_USE, 7'd8);
        write_reg(CFG_PAGES_IN_USE, 7'd64);
        write_reg(CFG_START_WRITE_BLOCK, 7'd0);
        run_random(100);
        drain();

        if (!failed) begin
            $display("tb_nand_page_state_tracker_core: PASS");
        end else begin
            $display("tb_nand_page_state_tracker_core: FAIL");
        end
        $finish;
    end

endmodule
